// ===== src/drc_pkg.sv =====
// Shared types, codes and box arithmetic for the dirty rectangle coalescer.
// No dependencies; every other file but drc_ram uses this package.
package drc_pkg;

  localparam int MAX_RECTS = 64;
  localparam int CRD_W     = 12;
  localparam int EXT_W     = 13;
  localparam int SPAN_W    = 14;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_COAL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [EXT_W-1:0] w;
    logic [EXT_W-1:0] h;
  } box_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_ADD,
    DP_READ,
    DP_READ_CAP,
    DP_PASS_START,
    DP_LOAD_I,
    DP_TAKE_I,
    DP_LOAD_J,
    DP_WB,
    DP_CMP,
    DP_SH_RD,
    DP_SH_WR,
    DP_DONE
  } dp_cmd_e;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic meet;
    logic tail_j;
    logic tail_k;
    logic changed;
    logic idx_ok;
  } dp_sts_t;

  // Overlap or shared edge: no gap between the two boxes on either axis.
  function automatic logic boxes_meet(box_t p, box_t q);
    logic [SPAN_W-1:0] p_xe, q_xe, p_ye, q_ye;
    p_xe = SPAN_W'(p.x) + SPAN_W'(p.w);
    q_xe = SPAN_W'(q.x) + SPAN_W'(q.w);
    p_ye = SPAN_W'(p.y) + SPAN_W'(p.h);
    q_ye = SPAN_W'(q.y) + SPAN_W'(q.h);
    return !((SPAN_W'(p.x) > q_xe) || (SPAN_W'(q.x) > p_xe) ||
             (SPAN_W'(p.y) > q_ye) || (SPAN_W'(q.y) > p_ye));
  endfunction

  // Bounding box, extents saturate at the field maximum.
  function automatic box_t box_absorb(box_t p, box_t q);
    logic [SPAN_W-1:0] p_xe, q_xe, p_ye, q_ye, hi_x, hi_y, nw, nh;
    logic [CRD_W-1:0]  lo_x, lo_y;
    box_t              r;
    p_xe = SPAN_W'(p.x) + SPAN_W'(p.w);
    q_xe = SPAN_W'(q.x) + SPAN_W'(q.w);
    p_ye = SPAN_W'(p.y) + SPAN_W'(p.h);
    q_ye = SPAN_W'(q.y) + SPAN_W'(q.h);
    lo_x = (p.x < q.x) ? p.x : q.x;
    lo_y = (p.y < q.y) ? p.y : q.y;
    hi_x = (p_xe > q_xe) ? p_xe : q_xe;
    hi_y = (p_ye > q_ye) ? p_ye : q_ye;
    nw   = hi_x - SPAN_W'(lo_x);
    nh   = hi_y - SPAN_W'(lo_y);
    r.x  = lo_x;
    r.y  = lo_y;
    r.w  = nw[SPAN_W-1] ? {EXT_W{1'b1}} : nw[EXT_W-1:0];
    r.h  = nh[SPAN_W-1] ? {EXT_W{1'b1}} : nh[EXT_W-1:0];
    return r;
  endfunction

endpackage

// ===== src/drc_req_if.sv =====
// Request channel of the dirty rectangle coalescer: valid/ready plus operation fields.
// Depends on drc_pkg for field widths.
interface drc_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [drc_pkg::CRD_W-1:0]       rect_x;
  logic [drc_pkg::CRD_W-1:0]       rect_y;
  logic [drc_pkg::EXT_W-1:0]       rect_w;
  logic [drc_pkg::EXT_W-1:0]       rect_h;
  logic [drc_pkg::IDX_W-1:0]       entry_index;

  modport source (output valid, opcode, rect_x, rect_y, rect_w, rect_h, entry_index,
                  input ready);
  modport sink   (input valid, opcode, rect_x, rect_y, rect_w, rect_h, entry_index,
                  output ready);
endinterface

// ===== src/drc_rsp_if.sv =====
// Result channel of the dirty rectangle coalescer: valid/ready plus result fields.
// Depends on drc_pkg for field widths.
interface drc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [drc_pkg::CNT_W-1:0]       entry_count;
  logic [drc_pkg::CRD_W-1:0]       out_x;
  logic [drc_pkg::CRD_W-1:0]       out_y;
  logic [drc_pkg::EXT_W-1:0]       out_w;
  logic [drc_pkg::EXT_W-1:0]       out_h;

  modport source (output valid, status, entry_count, out_x, out_y, out_w, out_h,
                  input ready);
  modport sink   (input valid, status, entry_count, out_x, out_y, out_w, out_h,
                  output ready);
endinterface

// ===== src/drc_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module drc_ram #(
  parameter int Width = 50,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/drc_datapath.sv =====
// Datapath: rectangle table, list count, pass indexes, merge logic and result register.
// Depends on drc_pkg and drc_ram; driven by commands from drc_ctrl.
module drc_datapath #(
  parameter int MaxRects = drc_pkg::MAX_RECTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drc_pkg::dp_cmd_e              cmd_i,
  output drc_pkg::dp_sts_t              sts_o,
  input  logic [drc_pkg::CRD_W-1:0]     rect_x_i,
  input  logic [drc_pkg::CRD_W-1:0]     rect_y_i,
  input  logic [drc_pkg::EXT_W-1:0]     rect_w_i,
  input  logic [drc_pkg::EXT_W-1:0]     rect_h_i,
  input  logic [drc_pkg::IDX_W-1:0]     entry_index_i,
  output logic [1:0]                    status_o,
  output logic [drc_pkg::CNT_W-1:0]     entry_count_o,
  output logic [drc_pkg::CRD_W-1:0]     out_x_o,
  output logic [drc_pkg::CRD_W-1:0]     out_y_o,
  output logic [drc_pkg::EXT_W-1:0]     out_w_o,
  output logic [drc_pkg::EXT_W-1:0]     out_h_o
);
  import drc_pkg::*;

  localparam int CW = $clog2(MaxRects + 1);
  localparam int AW = $clog2(MaxRects);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int BW = $bits(box_t);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          changed_q, changed_d;
  box_t          cur_q, cur_d;
  status_e       res_status_q, res_status_d;
  box_t          res_box_q, res_box_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  box_t          wdata, rdata;
  logic [BW-1:0] rdata_raw;

  logic          add_ok, idx_ok, meet, tail_j, tail_k;
  logic [XW-1:0] idx_ext, cnt_ext;
  logic [CW:0]   j_next, k_next2;

  drc_ram #(.Width(BW), .Depth(MaxRects)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rdata = box_t'(rdata_raw);

  assign idx_ext = XW'(entry_index_i);
  assign cnt_ext = XW'(count_q);
  assign idx_ok  = idx_ext < cnt_ext;
  assign add_ok  = (rect_w_i != '0) && (rect_h_i != '0) && (count_q != CW'(MaxRects));
  assign meet    = boxes_meet(cur_q, rdata);
  assign j_next  = {1'b0, j_q} + (CW+1)'(1);
  assign k_next2 = {1'b0, k_q} + (CW+1)'(2);
  assign tail_j  = j_next < {1'b0, count_q};
  assign tail_k  = k_next2 < {1'b0, count_q};

  assign sts_o.i_end   = i_q >= count_q;
  assign sts_o.j_end   = j_q >= count_q;
  assign sts_o.meet    = meet;
  assign sts_o.tail_j  = tail_j;
  assign sts_o.tail_k  = tail_k;
  assign sts_o.changed = changed_q;
  assign sts_o.idx_ok  = idx_ok;

  always_comb begin
    count_d      = count_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    changed_d    = changed_q;
    cur_d        = cur_q;
    res_status_d = res_status_q;
    res_box_d    = res_box_q;
    we           = 1'b0;
    waddr        = i_q[AW-1:0];
    wdata        = cur_q;
    raddr        = i_q[AW-1:0];
    case (cmd_i)
      DP_CLEAR: begin
        count_d      = '0;
        res_status_d = ST_OK;
        res_box_d    = '0;
      end
      DP_ADD: begin
        res_box_d = '0;
        if (add_ok) begin
          we           = 1'b1;
          waddr        = count_q[AW-1:0];
          wdata        = '{x: rect_x_i, y: rect_y_i, w: rect_w_i, h: rect_h_i};
          count_d      = count_q + CW'(1);
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_REJECT;
        end
      end
      DP_READ: begin
        raddr = AW'(entry_index_i);
        if (!idx_ok) begin
          res_status_d = ST_RANGE;
          res_box_d    = '0;
        end
      end
      DP_READ_CAP: begin
        res_status_d = ST_OK;
        res_box_d    = rdata;
      end
      DP_PASS_START: begin
        i_d       = '0;
        changed_d = 1'b0;
      end
      DP_LOAD_I: raddr = i_q[AW-1:0];
      DP_TAKE_I: begin
        cur_d = rdata;
        j_d   = i_q + CW'(1);
      end
      DP_LOAD_J: raddr = j_q[AW-1:0];
      DP_WB: begin
        we  = 1'b1;
        i_d = i_q + CW'(1);
      end
      DP_CMP: begin
        if (meet) begin
          cur_d     = box_absorb(cur_q, rdata);
          changed_d = 1'b1;
          k_d       = j_q;
          if (!tail_j) begin
            count_d = count_q - CW'(1);
          end
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      // shift the tail down one slot over the absorbed entry
      DP_SH_RD: raddr = AW'(k_q + CW'(1));
      DP_SH_WR: begin
        we    = 1'b1;
        waddr = k_q[AW-1:0];
        wdata = rdata;
        k_d   = k_q + CW'(1);
        if (!tail_k) begin
          count_d = count_q - CW'(1);
        end
      end
      DP_DONE: begin
        res_status_d = ST_OK;
        res_box_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      changed_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    res_status_q <= res_status_d;
    res_box_q    <= res_box_d;
  end

  assign status_o      = res_status_q;
  assign entry_count_o = CNT_W'(count_q);
  assign out_x_o       = res_box_q.x;
  assign out_y_o       = res_box_q.y;
  assign out_w_o       = res_box_q.w;
  assign out_h_o       = res_box_q.h;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxRects))
    else $error("list count above capacity");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == DP_CMP) |-> (j_q > i_q && j_q < count_q))
    else $error("pair compare outside list or out of order");
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == DP_SH_WR) |-> ({1'b0, k_q} + (CW+1)'(1) < {1'b0, count_q}))
    else $error("tail shift past end of list");
`endif
endmodule

// ===== src/drc_ctrl.sv =====
// Controller: request handshake, result valid, and the coalesce pass sequencer.
// Depends on drc_pkg; issues one datapath command per cycle.
module drc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [1:0]       req_opcode_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output drc_pkg::dp_cmd_e cmd_o,
  input  drc_pkg::dp_sts_t sts_i
);
  import drc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CAP,
    S_LOAD_I,
    S_TAKE_I,
    S_LOAD_J,
    S_CMP,
    S_SH_RD,
    S_SH_WR
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q;
  logic    load;
  logic    accept;
  dp_cmd_e cmd;

  assign req_ready_o = (state_q == S_IDLE) && (!out_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd     = DP_NOP;
    load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(req_opcode_i))
            OP_CLEAR: begin
              cmd  = DP_CLEAR;
              load = 1'b1;
            end
            OP_ADD: begin
              cmd  = DP_ADD;
              load = 1'b1;
            end
            OP_COAL: begin
              cmd     = DP_PASS_START;
              state_d = S_LOAD_I;
            end
            OP_READ: begin
              cmd = DP_READ;
              if (sts_i.idx_ok) begin
                state_d = S_RD_CAP;
              end else begin
                load = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_CAP: begin
        cmd     = DP_READ_CAP;
        load    = 1'b1;
        state_d = S_IDLE;
      end
      S_LOAD_I: begin
        if (!sts_i.i_end) begin
          cmd     = DP_LOAD_I;
          state_d = S_TAKE_I;
        end else if (sts_i.changed) begin
          cmd = DP_PASS_START;
        end else begin
          cmd     = DP_DONE;
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TAKE_I: begin
        cmd     = DP_TAKE_I;
        state_d = S_LOAD_J;
      end
      S_LOAD_J: begin
        if (sts_i.j_end) begin
          cmd     = DP_WB;
          state_d = S_LOAD_I;
        end else begin
          cmd     = DP_LOAD_J;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd     = DP_CMP;
        state_d = (sts_i.meet && sts_i.tail_j) ? S_SH_RD : S_LOAD_J;
      end
      S_SH_RD: begin
        cmd     = DP_SH_RD;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        cmd     = DP_SH_WR;
        state_d = sts_i.tail_k ? S_SH_RD : S_LOAD_J;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o       = cmd;
  assign rsp_valid_o = out_valid_q;

`ifndef SYNTH
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_RD_CAP) |-> !out_valid_q)
    else $error("result pending while coalescing");
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(req_opcode_i) == OP_CLEAR) |=> (out_valid_q && state_q == S_IDLE))
    else $error("clear gave no result");
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_CAP) |=> out_valid_q)
    else $error("read capture gave no result");
`endif
endmodule

// ===== src/dirty_rect_coalescer.sv =====
// Dirty rectangle coalescer: a bounded list of cell rectangles with clear, add, read and
// coalesce operations, one result per request. Clear, add and an out-of-range read load
// their result on acceptance; an in-range read loads it in S_RD_CAP after the table read.
// Coalesce repeats passes until one merges nothing; it starts the first pass in the accept
// cycle, then loads, takes and writes back each outer entry, loads and compares each pair,
// reads and writes each entry moved down after a merge, and closes each pass in S_LOAD_I.
// The pace is set by the single read port of the rectangle table, which every compare and
// every tail move goes through. A finished result waits in an output register; the next
// request is taken in the cycle that result is taken.
// Depends on drc_pkg, drc_req_if, drc_rsp_if, drc_ram, drc_datapath and drc_ctrl.
module dirty_rect_coalescer #(
  parameter int MaxRects = drc_pkg::MAX_RECTS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  drc_req_if.sink   req_i,
  drc_rsp_if.source rsp_o
);
  import drc_pkg::*;

  dp_cmd_e cmd;
  dp_sts_t sts;

  drc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_opcode_i (req_i.opcode),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  drc_datapath #(.MaxRects(MaxRects)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rect_x_i      (req_i.rect_x),
    .rect_y_i      (req_i.rect_y),
    .rect_w_i      (req_i.rect_w),
    .rect_h_i      (req_i.rect_h),
    .entry_index_i (req_i.entry_index),
    .status_o      (rsp_o.status),
    .entry_count_o (rsp_o.entry_count),
    .out_x_o       (rsp_o.out_x),
    .out_y_o       (rsp_o.out_y),
    .out_w_o       (rsp_o.out_w),
    .out_h_o       (rsp_o.out_h)
  );
endmodule

// ===== sim/drc_tb_pkg.sv =====
// Testbench-side shared definitions for the dirty rectangle coalescer bench.
// Depends on drc_pkg for widths, operation codes and status codes.
package drc_tb_pkg;
  import drc_pkg::*;

  typedef struct {
    op_e               op;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [EXT_W-1:0]  w;
    logic [EXT_W-1:0]  h;
    logic [IDX_W-1:0]  idx;
  } rect_req_t;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [EXT_W-1:0]  w;
    logic [EXT_W-1:0]  h;
  } rect_rsp_t;
endpackage

// ===== sim/dirty_rect_coalescer_tb.sv =====
// Bench for dirty_rect_coalescer: drives list operations over the request channel and checks
// each result against a behavioral list model. Depends on drc_pkg, drc_tb_pkg and both channels.
module dirty_rect_coalescer_tb;
  import drc_pkg::*;
  import drc_tb_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int RAND_ITEMS = 861;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  drc_req_if req_if ();
  drc_rsp_if rsp_if ();

  dirty_rect_coalescer dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if));

  // list model state
  int unsigned box_x[MAX_RECTS], box_y[MAX_RECTS], box_w[MAX_RECTS], box_h[MAX_RECTS];
  int unsigned list_len;

  rect_rsp_t pending_rsp[$];
  int        errors = 0;
  int        send_idle_pct = 10, recv_idle_pct = 54;
  int        hold_off = 0;
  bit        stim_done = 0;
  longint    cycles = 0;

  function automatic bit rects_touch(int unsigned a, int unsigned b);
    if (box_x[a] > box_x[b] + box_w[b] || box_x[b] > box_x[a] + box_w[a]) return 0;
    if (box_y[a] > box_y[b] + box_h[b] || box_y[b] > box_y[a] + box_h[a]) return 0;
    return 1;
  endfunction

  function automatic void merge_into(int unsigned a, int unsigned b);
    int unsigned lx, ly, hx, hy;
    lx = box_x[a] < box_x[b] ? box_x[a] : box_x[b];
    ly = box_y[a] < box_y[b] ? box_y[a] : box_y[b];
    hx = (box_x[a] + box_w[a]) > (box_x[b] + box_w[b]) ?
         box_x[a] + box_w[a] : box_x[b] + box_w[b];
    hy = (box_y[a] + box_h[a]) > (box_y[b] + box_h[b]) ?
         box_y[a] + box_h[a] : box_y[b] + box_h[b];
    box_x[a] = lx;
    box_y[a] = ly;
    box_w[a] = (hx - lx) > 8191 ? 8191 : hx - lx;
    box_h[a] = (hy - ly) > 8191 ? 8191 : hy - ly;
  endfunction

  function automatic void coalesce_list();
    bit changed;
    int unsigned i, j, k;
    do begin
      changed = 0;
      for (i = 0; i < list_len; i++) begin
        j = i + 1;
        while (j < list_len) begin
          if (rects_touch(i, j)) begin
            merge_into(i, j);
            for (k = j; k + 1 < list_len; k++) begin
              box_x[k] = box_x[k+1]; box_y[k] = box_y[k+1];
              box_w[k] = box_w[k+1]; box_h[k] = box_h[k+1];
            end
            list_len--;
            changed = 1;
          end else begin
            j++;
          end
        end
      end
    end while (changed);
  endfunction

  function automatic rect_rsp_t predict_list_op(rect_req_t r);
    rect_rsp_t e;
    e = '{ST_OK, '0, '0, '0, '0, '0};
    case (r.op)
      OP_CLEAR: list_len = 0;
      OP_ADD: begin
        if (r.w == 0 || r.h == 0 || list_len >= MAX_RECTS) begin
          e.status = ST_REJECT;
        end else begin
          box_x[list_len] = r.x; box_y[list_len] = r.y;
          box_w[list_len] = r.w; box_h[list_len] = r.h;
          list_len++;
        end
      end
      OP_COAL: coalesce_list();
      default: begin
        if (r.idx >= list_len) begin
          e.status = ST_RANGE;
        end else begin
          e.x = CRD_W'(box_x[r.idx]); e.y = CRD_W'(box_y[r.idx]);
          e.w = EXT_W'(box_w[r.idx]); e.h = EXT_W'(box_h[r.idx]);
        end
      end
    endcase
    e.count = list_len[CNT_W-1:0];
    return e;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.rect_x = '0;
    req_if.rect_y = '0;
    req_if.rect_w = '0;
    req_if.rect_h = '0;
    req_if.entry_index = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // Watchdog: end the run on a stuck handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls plus two long hold-offs.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rect_rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with none expected: status %0d count %0d", $realtime,
                 rsp_if.status, rsp_if.entry_count);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_if.status !== e.status || rsp_if.entry_count !== e.count ||
            rsp_if.out_x !== e.x || rsp_if.out_y !== e.y ||
            rsp_if.out_w !== e.w || rsp_if.out_h !== e.h) begin
          $display({"%0t: expected st %0d cnt %0d box %0d,%0d %0dx%0d, ",
                    "got st %0d cnt %0d box %0d,%0d %0dx%0d"},
                   $realtime, e.status, e.count, e.x, e.y, e.w, e.h,
                   rsp_if.status, rsp_if.entry_count, rsp_if.out_x, rsp_if.out_y,
                   rsp_if.out_w, rsp_if.out_h);
          errors++;
        end
      end
    end
  end

  // Offer one request, hold it until taken; the model's prediction is checked against the table value if given.
  task automatic send_request(rect_req_t r, bit has_fixed, rect_rsp_t fixed);
    rect_rsp_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= r.op;
    req_if.rect_x <= r.x;
    req_if.rect_y <= r.y;
    req_if.rect_w <= r.w;
    req_if.rect_h <= r.h;
    req_if.entry_index <= r.idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    e = predict_list_op(r);
    if (has_fixed && e != fixed) begin
      $display({"%0t: table row expected st %0d cnt %0d box %0d,%0d %0dx%0d, ",
                "model st %0d cnt %0d"},
               $realtime, fixed.status, fixed.count, fixed.x, fixed.y, fixed.w, fixed.h,
               e.status, e.count);
      errors++;
    end
    pending_rsp.push_back(e);
    @(negedge clk_i);
  endtask

  function automatic rect_req_t mk(op_e op, int x, int y, int w, int h, int idx);
    rect_req_t r;
    r.op = op; r.x = CRD_W'(x); r.y = CRD_W'(y); r.w = EXT_W'(w); r.h = EXT_W'(h);
    r.idx = IDX_W'(idx);
    return r;
  endfunction

  function automatic rect_req_t random_request(int span);
    rect_req_t r;
    int sel;
    sel = $urandom_range(99);
    if (sel < 3) r.op = OP_CLEAR;
    else if (sel < 60) r.op = OP_ADD;
    else if (sel < 72) r.op = OP_COAL;
    else r.op = OP_READ;
    r.x = CRD_W'($urandom_range(span));
    r.y = CRD_W'($urandom_range(span));
    r.w = $urandom_range(99) < 4 ? '0 : EXT_W'($urandom_range(span / 4 + 1));
    r.h = $urandom_range(99) < 4 ? '0 : EXT_W'($urandom_range(span / 4 + 1));
    if ($urandom_range(99) < 5) begin
      r.x = CRD_W'($urandom); r.y = CRD_W'($urandom);
      r.w = EXT_W'($urandom); r.h = EXT_W'($urandom);
    end
    r.idx = IDX_W'(($urandom_range(99) < 80) ? $urandom_range(list_len + 1)
                                              : $urandom_range(63));
    return r;
  endfunction

  typedef struct {
    rect_req_t req;
    bit        has_fixed;
    rect_rsp_t fixed;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    rect_rsp_t  none;
    int         phase, n, span;
    none = '{ST_OK, '0, '0, '0, '0, '0};
    rows = '{
      '{mk(OP_READ, 0, 0, 0, 0, 0), 1, '{ST_RANGE, 0, 0, 0, 0, 0}},
      '{mk(OP_COAL, 0, 0, 0, 0, 0), 1, '{ST_OK, 0, 0, 0, 0, 0}},
      '{mk(OP_ADD, 5, 5, 0, 3, 0), 1, '{ST_REJECT, 0, 0, 0, 0, 0}},
      '{mk(OP_ADD, 5, 5, 3, 0, 0), 1, '{ST_REJECT, 0, 0, 0, 0, 0}},
      '{mk(OP_ADD, 4095, 4095, 8191, 8191, 0), 1, '{ST_OK, 1, 0, 0, 0, 0}},
      '{mk(OP_READ, 0, 0, 0, 0, 0), 1, '{ST_OK, 1, 4095, 4095, 8191, 8191}},
      '{mk(OP_ADD, 0, 0, 4096, 4096, 0), 1, '{ST_OK, 2, 0, 0, 0, 0}},
      '{mk(OP_READ, 0, 0, 0, 0, 63), 1, '{ST_RANGE, 2, 0, 0, 0, 0}},
      '{mk(OP_COAL, 0, 0, 0, 0, 0), 0, none},
      '{mk(OP_READ, 0, 0, 0, 0, 0), 1, '{ST_OK, 1, 0, 0, 8191, 8191}},
      '{mk(OP_CLEAR, 0, 0, 0, 0, 0), 1, '{ST_OK, 0, 0, 0, 0, 0}},
      '{mk(OP_ADD, 0, 0, 10, 10, 0), 0, none},
      '{mk(OP_ADD, 10, 0, 5, 5, 0), 0, none},
      '{mk(OP_ADD, 100, 100, 1, 1, 0), 0, none},
      '{mk(OP_ADD, 102, 100, 1, 1, 0), 0, none},
      '{mk(OP_ADD, 0, 15, 1, 1, 0), 0, none},
      '{mk(OP_COAL, 0, 0, 0, 0, 0), 0, none},
      '{mk(OP_READ, 0, 0, 0, 0, 0), 0, none},
      '{mk(OP_READ, 0, 0, 0, 0, 1), 0, none},
      '{mk(OP_READ, 0, 0, 0, 0, 2), 0, none},
      '{mk(OP_CLEAR, 0, 0, 0, 0, 0), 0, none}
    };
    list_len = 0;
    wait (rst_ni);
    @(negedge clk_i);
    foreach (rows[k]) send_request(rows[k].req, rows[k].has_fixed, rows[k].fixed);
    // Fill to capacity with far-apart boxes, reject one more, read the last slot.
    for (n = 0; n < MAX_RECTS; n++)
      send_request(mk(OP_ADD, (n % 8) * 500, (n / 8) * 500, 1 + n % 3, 1, 0), 0, none);
    hold_off = 200;
    send_request(mk(OP_ADD, 1, 1, 1, 1, 0), 1, '{ST_REJECT, 64, 0, 0, 0, 0});
    send_request(mk(OP_READ, 0, 0, 0, 0, 63), 0, none);
    send_request(mk(OP_COAL, 0, 0, 0, 0, 0), 0, none);
    send_request(mk(OP_CLEAR, 0, 0, 0, 0, 0), 0, none);
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 10 : phase == 1 ? 54 : 0;
      recv_idle_pct = phase == 0 ? 54 : phase == 1 ? 10 : 0;
      for (n = 0; n < RAND_ITEMS / 3; n++) begin
        // mostly dense boxes so merges chain; sometimes spread them over the grid
        span = (n % 50 < 40) ? 200 : 4095;
        if (n == 150 && phase == 2) hold_off = 300;
        send_request(random_request(span), 0, none);
      end
    end
    req_if.valid <= 1'b0;
    stim_done = 1;
    wait (pending_rsp.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    wait (stim_done);
    repeat (200000) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $display("%0t: results still outstanding: %0d", $realtime, pending_rsp.size());
      $display("FAIL");
      $finish;
    end
  end
endmodule
